[hw/rtl/mqsb_pkg.sv]
// Shared types and constants for the multi-queue shared buffer.
package mqsb_pkg;

  // Fixed port widths
  localparam int QueueIdW  = 2;
  localparam int PortWordW = 32;
  localparam int StatusW   = 2;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;   // capture the incoming transaction, start queue table read
    logic commit;  // apply all updates and load the result
  } cmd_t;

endpackage

[hw/rtl/mqsb_ram.sv]
// Generic single write port, single read port RAM with registered read.
module mqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/mqsb_ctrl.sv]
// Sequencer for one push or pop transaction: accept, lookup, commit.
module mqsb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output mqsb_pkg::cmd_t cmd
);

  import mqsb_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/mqsb_datapath.sv]
// Pointer registers, queue table, link and slot memories, and result registers.
module mqsb_datapath #(
  parameter int SLOT_COUNT  = 16,
  parameter int QUEUE_COUNT = 4,
  parameter int WORD_WIDTH  = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mqsb_pkg::cmd_t                     cmd,
  input  logic                               operation,
  input  logic [mqsb_pkg::QueueIdW-1:0]      queue_id,
  input  logic signed [mqsb_pkg::PortWordW-1:0] push_word,
  output logic                               done,
  output logic signed [mqsb_pkg::PortWordW-1:0] pop_word,
  output logic [mqsb_pkg::StatusW-1:0]       status
);

  import mqsb_pkg::*;

  localparam int SlotW = $clog2(SLOT_COUNT);
  localparam int PtrW  = $clog2(SLOT_COUNT + 1);
  localparam int QW    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam logic [PtrW-1:0] NullPtr = PtrW'(SLOT_COUNT);

  // Latched transaction
  logic                  op_r;
  logic [QW-1:0]         qid_r;
  logic                  q_ok_r;
  logic [WORD_WIDTH-1:0] word_r;

  // Free list head and count of slots ever taken from the initial chain
  logic [PtrW-1:0]        free_head;
  logic [PtrW-1:0]        fresh;
  logic [QUEUE_COUNT-1:0] empty;

  // Memory ports
  logic [QW-1:0]         qt_raddr;
  logic [2*PtrW-1:0]     qt_rdata;
  logic                  qt_we;
  logic [2*PtrW-1:0]     qt_wdata;
  logic [SlotW-1:0]      mem_raddr;
  logic [PtrW-1:0]       link_rdata;
  logic                  link_we;
  logic [SlotW-1:0]      link_waddr;
  logic [PtrW-1:0]       link_wdata;
  logic                  store_we;
  logic [WORD_WIDTH-1:0] store_rdata;

  // Commit decode
  logic            is_push;
  logic            q_empty;
  logic            push_ok;
  logic            pop_ok;
  logic            single;
  logic [PtrW-1:0] head;
  logic [PtrW-1:0] tail;
  logic [PtrW-1:0] new_head;

  assign head    = qt_rdata[2*PtrW-1:PtrW];
  assign tail    = qt_rdata[PtrW-1:0];
  assign is_push = (op_r == OP_PUSH);
  assign q_empty = empty[qid_r];
  assign single  = (head == tail);
  assign push_ok = is_push && q_ok_r && (free_head < NullPtr);
  assign pop_ok  = !is_push && q_ok_r && !q_empty;
  // last element of a queue has no valid link: the tail match marks it
  assign new_head = single ? NullPtr : link_rdata;

  // Read addresses: queue table during accept, then link and slot at the target slot
  assign qt_raddr  = cmd.latch ? QW'(queue_id) : qid_r;
  assign mem_raddr = (op_r == OP_PUSH) ? free_head[SlotW-1:0] : head[SlotW-1:0];

  // Write side, active only in the commit cycle of a successful transaction
  always_comb begin
    qt_we      = 1'b0;
    qt_wdata   = qt_rdata;
    link_we    = 1'b0;
    link_waddr = tail[SlotW-1:0];
    link_wdata = free_head;
    store_we   = cmd.commit && push_ok;
    if (cmd.commit && push_ok) begin
      qt_we      = 1'b1;
      qt_wdata   = {(q_empty ? free_head : head), free_head};
      link_we    = !q_empty;
      link_waddr = tail[SlotW-1:0];
      link_wdata = free_head;
    end else if (cmd.commit && pop_ok) begin
      qt_we      = 1'b1;
      qt_wdata   = {new_head, tail};
      link_we    = 1'b1;
      link_waddr = head[SlotW-1:0];
      link_wdata = free_head;
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= operation;
      qid_r  <= QW'(queue_id);
      q_ok_r <= (32'(queue_id) < QUEUE_COUNT);
      word_r <= WORD_WIDTH'(push_word);
    end
  end

  // Free list, fill count and empty flags
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fresh     <= '0;
      empty     <= '1;
    end else if (cmd.commit) begin
      if (push_ok) begin
        empty[qid_r] <= 1'b0;
        if (free_head == fresh) begin
          // untouched slot: its link is the next slot in order
          free_head <= free_head + 1'b1;
          fresh     <= fresh + 1'b1;
        end else begin
          free_head <= link_rdata;
        end
      end else if (pop_ok) begin
        free_head <= head;
        if (single) begin
          empty[qid_r] <= 1'b1;
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
    end
    if (cmd.commit) begin
      if (is_push) begin
        pop_word <= '0;
        status   <= push_ok ? STATUS_DONE : STATUS_FULL;
      end else if (pop_ok) begin
        pop_word <= PortWordW'($signed(store_rdata));
        status   <= STATUS_DONE;
      end else begin
        pop_word <= '1;
        status   <= STATUS_EMPTY;
      end
    end
  end

  // Queue table: head and tail per queue
  mqsb_ram #(
    .WIDTH (2 * PtrW),
    .DEPTH (QUEUE_COUNT)
  ) u_qtable (
    .clk   (clk),
    .we    (qt_we),
    .waddr (qid_r),
    .wdata (qt_wdata),
    .raddr (qt_raddr),
    .rdata (qt_rdata)
  );

  // Link table
  mqsb_ram #(
    .WIDTH (PtrW),
    .DEPTH (SLOT_COUNT)
  ) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (mem_raddr),
    .rdata (link_rdata)
  );

  // Slot store
  mqsb_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (free_head[SlotW-1:0]),
    .wdata (word_r),
    .raddr (mem_raddr),
    .rdata (store_rdata)
  );

endmodule

[hw/rtl/multi_queue_shared_buffer.sv]
// Top level: several FIFO queues linked through one shared slot store.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   --------------------------
//  command   operation, queue_id, push_word          start && !busy
//  result    pop_word, status                        done, one cycle, no stall
//
// Each transaction runs through accept (queue table read), lookup (link
// and slot memory read at the target slot) and commit (all writes) in
// order, as set by the two chained registered reads of the queue table
// and then the link and slot memories. done is high in the cycle after
// commit, when a new start can already be taken. No clearing pass
// follows reset: a fill count stands in for the initial free chain.
module multi_queue_shared_buffer #(
  parameter int SLOT_COUNT  = 16,
  parameter int QUEUE_COUNT = 4,
  parameter int WORD_WIDTH  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  operation,
  input  logic [mqsb_pkg::QueueIdW-1:0]         queue_id,
  input  logic signed [mqsb_pkg::PortWordW-1:0] push_word,
  output logic                                  done,
  output logic signed [mqsb_pkg::PortWordW-1:0] pop_word,
  output logic [mqsb_pkg::StatusW-1:0]          status
);

  import mqsb_pkg::*;

  cmd_t cmd;

  // Sequencer
  mqsb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Storage and update logic
  mqsb_datapath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .QUEUE_COUNT (QUEUE_COUNT),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (operation),
    .queue_id  (queue_id),
    .push_word (push_word),
    .done      (done),
    .pop_word  (pop_word),
    .status    (status)
  );

endmodule
